// File: rtl/nmea_rmc_line_filter_defines.svh
// Assertion macros for the checker file.
`ifndef NMEA_RMC_LINE_FILTER_DEFINES_SVH
`define NMEA_RMC_LINE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NRLF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrlf assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define NRLF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrlf assertion failed");

`endif

// File: rtl/nrlf_pkg.sv
package nrlf_pkg;

    // bytes kept per stored field
    localparam int FIELD_CHARS = 14;
    localparam int LEN_W       = $clog2(FIELD_CHARS + 1);
    localparam int RAM_DEPTH   = 3 * FIELD_CHARS;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int PC_W        = 4;

    localparam int WORD_LEN   = 11;
    localparam int TAG_LEN    = 6;
    localparam int MIN_COMMAS = 10;
    localparam logic [3:0] MISMATCH = 4'd15;
    localparam logic [3:0] SAT_MAX  = 4'd15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // field buffers share one RAM
    localparam logic [1:0] FLD_UTC = 2'd0;
    localparam logic [1:0] FLD_LAT = 2'd1;
    localparam logic [1:0] FLD_LON = 2'd2;
    localparam logic [ADDR_W-1:0] BASE_UTC = '0;
    localparam logic [ADDR_W-1:0] BASE_LAT = ADDR_W'(FIELD_CHARS);
    localparam logic [ADDR_W-1:0] BASE_LON = ADDR_W'(2 * FIELD_CHARS);

    // program entry points
    localparam logic [PC_W-1:0] PC_ECHO = 4'd0;
    localparam logic [PC_W-1:0] PC_NL   = 4'd1;
    localparam logic [PC_W-1:0] PC_RST  = 4'd2;
    localparam logic [PC_W-1:0] PC_LINE = 4'd3;

    typedef enum logic [1:0] {
        OP_CONST,   // emit constant byte
        OP_BYTE,    // emit latched input byte
        OP_FETCH,   // read next field byte, or jump when field done
        OP_RAM      // emit RAM read data, loop back
    } uop_t;

    typedef struct packed {
        uop_t            op;
        logic [7:0]      ch;
        logic [1:0]      fld;
        logic            last;
        logic            rst;
        logic            fin;
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t mk(input uop_t op, input logic [7:0] ch, input logic [1:0] fld,
                                  input logic last, input logic fin,
                                  input logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.ch     = ch;
        w.fld    = fld;
        w.last   = last;
        w.rst    = 1'b0;
        w.fin    = fin;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:    w = mk(OP_BYTE,  CH_NUL,   FLD_UTC, 1'b1, 1'b1, 4'd0);
            4'd1:    w = mk(OP_CONST, CH_LF,    FLD_UTC, 1'b1, 1'b1, 4'd0);
            4'd2:
            begin
                w     = mk(OP_CONST, CH_NUL, FLD_UTC, 1'b1, 1'b1, 4'd0);
                w.rst = 1'b1;
            end
            4'd3:    w = mk(OP_CONST, CH_C,     FLD_UTC, 1'b0, 1'b0, 4'd0);
            4'd4:    w = mk(OP_CONST, CH_COMMA, FLD_UTC, 1'b0, 1'b0, 4'd0);
            4'd5:    w = mk(OP_FETCH, CH_NUL,   FLD_UTC, 1'b0, 1'b0, 4'd7);
            4'd6:    w = mk(OP_RAM,   CH_NUL,   FLD_UTC, 1'b0, 1'b0, 4'd5);
            4'd7:    w = mk(OP_CONST, CH_COMMA, FLD_UTC, 1'b0, 1'b0, 4'd0);
            4'd8:    w = mk(OP_FETCH, CH_NUL,   FLD_LAT, 1'b0, 1'b0, 4'd10);
            4'd9:    w = mk(OP_RAM,   CH_NUL,   FLD_LAT, 1'b0, 1'b0, 4'd8);
            4'd10:   w = mk(OP_CONST, CH_COMMA, FLD_LAT, 1'b0, 1'b0, 4'd0);
            4'd11:   w = mk(OP_FETCH, CH_NUL,   FLD_LON, 1'b0, 1'b0, 4'd13);
            4'd12:   w = mk(OP_RAM,   CH_NUL,   FLD_LON, 1'b0, 1'b0, 4'd11);
            4'd13:   w = mk(OP_CONST, CH_LF,    FLD_LON, 1'b1, 1'b1, 4'd0);
            default: w = mk(OP_CONST, CH_LF,    FLD_UTC, 1'b1, 1'b1, 4'd0);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] reset_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h53; // S
            4'd1:    c = 8'h79; // y
            4'd2:    c = 8'h73; // s
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6D; // m
            4'd6:    c = 8'h52; // R
            4'd7:    c = 8'h65; // e
            4'd8:    c = 8'h73; // s
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24; // $
            3'd1:    c = 8'h47; // G
            3'd2:    c = 8'h50; // P
            3'd3:    c = 8'h52; // R
            3'd4:    c = 8'h4D; // M
            3'd5:    c = 8'h43; // C
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/nrlf_ram.sv
module nrlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 42
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/nmea_rmc_line_filter.sv
// NMEA RMC line filter. Takes serial bytes one beat at a time (rx_byte) and
// sends result beats (tx_byte, last_of_run, reset_request); last_of_run marks
// the final beat caused by one input beat. Lines end at CR or LF. A line that
// starts with 'P' is echoed beat for beat, with a newline at its end. A line
// that is exactly "SystemReset" gives one beat with reset_request set and
// tx_byte zero. Other lines are split at commas; utc (field 1), latitude
// (field 3) and longitude (field 5 less its first byte) are kept in a small
// RAM, and at line end, if the line has at least 10 commas, field 0 is
// "$GPRMC", field 2 is "A" and no kept field (lon with its dropped byte)
// outgrew FIELD_CHARS bytes, the block sends "C," utc "," lat "," lon "\n".
// Timing: a byte inside a parsed line is taken without stalling the input;
// an echo byte or single-beat line end keeps input stalled until that beat
// is in the output register. After the terminator a coordinate line is sent
// by the microcode sequencer: one step per fixed byte, two per stored byte
// (RAM read, then emit) and one closing step per field; a stalled output
// holds the sequencer at its emit steps. The output register lets the last
// beat wait while the next byte is accepted.
module nmea_rmc_line_filter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       last_of_run,
    output logic       reset_request
);
    import nrlf_pkg::*;

    typedef enum logic [1:0] {
        LC_START,   // no byte of the line seen yet
        LC_ECHO,    // 'P' line, echoed
        LC_OTHER    // parsed line
    } line_class_t;

    // sequencer
    logic                  busy_reg, busy_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [LEN_W-1:0]      idx_reg, idx_next;
    logic [7:0]            byte_reg, byte_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            tx_byte_reg, tx_byte_next;
    logic                  last_reg, last_next;
    logic                  rst_req_reg, rst_req_next;

    // line state
    line_class_t           class_reg, class_next;
    logic [3:0]            match_reg, match_next;
    logic [3:0]            comma_reg, comma_next;
    logic [3:0]            col_reg, col_next;
    logic                  tag_reg, tag_next;
    logic                  status_reg, status_next;
    logic                  ovf_reg, ovf_next;
    logic [LEN_W-1:0]      utc_len_reg, utc_len_next;
    logic [LEN_W-1:0]      lat_len_reg, lat_len_next;
    logic [LEN_W-1:0]      lon_len_reg, lon_len_next;

    // field RAM ports
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [7:0]            rd_data;

    uword_t                uw;
    logic                  in_fire;
    logic                  out_free;
    logic                  is_eol;
    logic                  line_ok;
    line_class_t           class_now;
    logic [LEN_W-1:0]      sel_len;
    logic [ADDR_W-1:0]     sel_base;

    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign uw       = ucode_rom(pc_reg);
    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign line_ok  = (class_reg != LC_START) && (comma_reg >= 4'(MIN_COMMAS))
                      && tag_reg && status_reg && !ovf_reg;
    assign class_now = (class_reg == LC_START)
                       ? ((rx_byte == CH_P) ? LC_ECHO : LC_OTHER) : class_reg;

    always_comb
    begin
        case (uw.fld)
            FLD_UTC:
            begin
                sel_len  = utc_len_reg;
                sel_base = BASE_UTC;
            end
            FLD_LAT:
            begin
                sel_len  = lat_len_reg;
                sel_base = BASE_LAT;
            end
            default:
            begin
                sel_len  = lon_len_reg;
                sel_base = BASE_LON;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        rst_req_next   = rst_req_reg;
        class_next     = class_reg;
        match_next     = match_reg;
        comma_next     = comma_reg;
        col_next       = col_reg;
        tag_next       = tag_reg;
        status_next    = status_reg;
        ovf_next       = ovf_reg;
        utc_len_next   = utc_len_reg;
        lat_len_next   = lat_len_reg;
        lon_len_next   = lon_len_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = sel_base + ADDR_W'(idx_reg);

        // sequencer: one control word per step
        if (busy_reg)
        begin
            case (uw.op)
                OP_FETCH:
                begin
                    if (idx_reg < sel_len)
                    begin
                        rd_en   = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                    else
                    begin
                        idx_next = '0;
                        pc_next  = uw.target;
                    end
                end
                default:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        last_next      = uw.last;
                        rst_req_next   = uw.rst;
                        case (uw.op)
                            OP_BYTE: tx_byte_next = byte_reg;
                            OP_RAM:  tx_byte_next = rd_data;
                            default: tx_byte_next = uw.ch;
                        endcase
                        if (uw.fin)
                        begin
                            busy_next    = 1'b0;
                            utc_len_next = '0;
                            lat_len_next = '0;
                            lon_len_next = '0;
                        end
                        else if (uw.op == OP_RAM)
                        begin
                            pc_next  = uw.target;
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                end
            endcase
        end

        // input side, only while the sequencer is idle
        if (in_fire)
        begin
            if (is_eol)
            begin
                class_next  = LC_START;
                match_next  = '0;
                comma_next  = '0;
                col_next    = '0;
                tag_next    = 1'b1;
                status_next = 1'b1;
                ovf_next    = 1'b0;
                idx_next    = '0;
                if (class_reg == LC_ECHO)
                begin
                    busy_next = 1'b1;
                    pc_next   = PC_NL;
                end
                else if (match_reg == 4'(WORD_LEN))
                begin
                    busy_next = 1'b1;
                    pc_next   = PC_RST;
                end
                else if (line_ok)
                begin
                    busy_next = 1'b1;
                    pc_next   = PC_LINE;
                end
                else
                begin
                    utc_len_next = '0;
                    lat_len_next = '0;
                    lon_len_next = '0;
                end
            end
            else
            begin
                class_next = class_now;
                if (class_now == LC_ECHO)
                begin
                    byte_next = rx_byte;
                    busy_next = 1'b1;
                    pc_next   = PC_ECHO;
                end
                else
                begin
                    if ((match_reg < 4'(WORD_LEN)) && (rx_byte == reset_char(match_reg)))
                    begin
                        match_next = match_reg + 1'b1;
                    end
                    else
                    begin
                        match_next = MISMATCH;
                    end

                    if (rx_byte == CH_COMMA)
                    begin
                        if ((comma_reg == 4'd0) && (col_reg != 4'(TAG_LEN)))
                        begin
                            tag_next = 1'b0;
                        end
                        if ((comma_reg == 4'd2) && (col_reg != 4'd1))
                        begin
                            status_next = 1'b0;
                        end
                        if (comma_reg != SAT_MAX)
                        begin
                            comma_next = comma_reg + 1'b1;
                        end
                        col_next = '0;
                    end
                    else
                    begin
                        case (comma_reg)
                            4'd0:
                            begin
                                if ((col_reg >= 4'(TAG_LEN)) ||
                                    (rx_byte != tag_char(col_reg[2:0])))
                                begin
                                    tag_next = 1'b0;
                                end
                            end
                            4'd1:
                            begin
                                if (utc_len_reg >= LEN_W'(FIELD_CHARS))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en        = 1'b1;
                                    wr_addr      = BASE_UTC + ADDR_W'(utc_len_reg);
                                    utc_len_next = utc_len_reg + 1'b1;
                                end
                            end
                            4'd2:
                            begin
                                if ((col_reg != 4'd0) || (rx_byte != CH_A))
                                begin
                                    status_next = 1'b0;
                                end
                            end
                            4'd3:
                            begin
                                if (lat_len_reg >= LEN_W'(FIELD_CHARS))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en        = 1'b1;
                                    wr_addr      = BASE_LAT + ADDR_W'(lat_len_reg);
                                    lat_len_next = lat_len_reg + 1'b1;
                                end
                            end
                            4'd5:
                            begin
                                // first longitude byte is dropped
                                if (col_reg != 4'd0)
                                begin
                                    if (lon_len_reg >= LEN_W'(FIELD_CHARS - 1))
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        wr_en        = 1'b1;
                                        wr_addr      = BASE_LON + ADDR_W'(lon_len_reg);
                                        lon_len_next = lon_len_reg + 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (col_reg != SAT_MAX)
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            class_reg     <= LC_START;
            match_reg     <= '0;
            comma_reg     <= '0;
            col_reg       <= '0;
            tag_reg       <= 1'b1;
            status_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
            utc_len_reg   <= '0;
            lat_len_reg   <= '0;
            lon_len_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            class_reg     <= class_next;
            match_reg     <= match_next;
            comma_reg     <= comma_next;
            col_reg       <= col_next;
            tag_reg       <= tag_next;
            status_reg    <= status_next;
            ovf_reg       <= ovf_next;
            utc_len_reg   <= utc_len_next;
            lat_len_reg   <= lat_len_next;
            lon_len_reg   <= lon_len_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        tx_byte_reg <= tx_byte_next;
        last_reg    <= last_next;
        rst_req_reg <= rst_req_next;
    end

    nrlf_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_field_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign last_of_run   = last_reg;
    assign reset_request = rst_req_reg;

endmodule

// File: rtl/nrlf_checker.sv
`include "nmea_rmc_line_filter_defines.svh"

module nrlf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] tx_byte,
    input logic       last_of_run,
    input logic       reset_request
);

    // stalled result beat holds
    `NRLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(last_of_run) && $stable(reset_request))

    // reset request is a lone beat with a zero byte
    `NRLF_ASSERT_NOW(a_rst_beat, out_valid && reset_request, last_of_run && (tx_byte == 8'h00))

    // input stays stalled while a run is still being sent
    `NRLF_ASSERT_NOW(a_run_busy, out_valid && !last_of_run, !in_ready)

endmodule

bind nmea_rmc_line_filter nrlf_checker u_nrlf_checker (.*);
